/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted (active low).
`define MCDC_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("mcdc assertion failed");

// Clocked assertion that also holds across reset.
`define MCDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mcdc assertion failed");

`endif

/* rtl/mcdc_pkg.sv */
// Shared types and constants of the multichannel delta codec.
// No dependencies; modules import it inside their bodies.
package mcdc_pkg;

    localparam int BYTE_W      = 8;
    localparam int PREV_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WORD_BYTES    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input byte into the buffer
        logic emit;     // load one result byte and advance
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_work;   // the byte being offered produces results
        logic out_free;     // output register can take a byte
        logic more;         // another byte follows the one being emitted
    } stat_t;

endpackage

/* rtl/mcdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mcdc_ctrl.sv */
// Sequencer of the multichannel delta codec: accept, read, emit.
// Depends on mcdc_pkg.
module mcdc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mcdc_pkg::stat_t stat,
    output mcdc_pkg::cmd_t  cmd
);

    import mcdc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.start_work) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // buffer read data lands in the next cycle
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.more ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/mcdc_datapath.sv */
// Datapath of the multichannel delta codec: configuration, sample buffer,
// per-channel previous words, byte-serial add/subtract and output register.
// Depends on mcdc_pkg and mcdc_ram.
module mcdc_datapath #(
    parameter int MAX_CHANNELS     = 16,
    parameter int MAX_SAMPLE_BYTES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mcdc_pkg::cmd_t                      cmd,
    output mcdc_pkg::stat_t                     stat,
    input  logic [mcdc_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                in_end,
    input  logic                                cfg_valid,
    input  logic [mcdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [mcdc_pkg::BYTE_W-1:0]         m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    import mcdc_pkg::*;

    localparam int AW = (MAX_SAMPLE_BYTES > 1) ? $clog2(MAX_SAMPLE_BYTES) : 1;
    localparam int FW = $clog2(MAX_SAMPLE_BYTES + 1);
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam logic [6:0]  LIM1      = 7'(MAX_SAMPLE_BYTES);
    localparam logic [6:0]  LIM2      = 7'(MAX_SAMPLE_BYTES / 2);
    localparam logic [6:0]  LIM3      = 7'(MAX_SAMPLE_BYTES / 3);
    localparam logic [6:0]  LIM4      = 7'(MAX_SAMPLE_BYTES / 4);
    localparam logic [6:0]  MAXCH     = 7'(MAX_CHANNELS);
    localparam logic [AW:0] DEPTH_X   = (AW + 1)'(MAX_SAMPLE_BYTES);
    localparam logic [AW-1:0] HEAD_LAST = AW'(MAX_SAMPLE_BYTES - 1);

    // configuration
    logic       dir_reg;
    logic [4:0] chan_cnt_reg;
    logic [2:0] word_reg;

    // buffer bookkeeping and previous words
    logic [AW-1:0]     head_reg;
    logic [FW-1:0]     fill_reg;
    logic [PREV_W-1:0] prev_reg [MAX_CHANNELS];

    // per-run sequencing
    logic          end_reg;
    logic          raw_reg;
    logic [FW-1:0] samp_left_reg;
    logic [CW-1:0] chan_reg;
    logic [1:0]    byte_reg;
    logic          carry_reg;
    logic [PREV_W-1:0] acc_reg;

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_raw_reg;

    logic [2:0]    w;
    logic [1:0]    w_m1;
    logic [6:0]    lim;
    logic [6:0]    c7;
    logic [4:0]    nch;
    logic [7:0]    ssize_w;
    logic [FW-1:0] ssize;

    logic [FW-1:0] fill_inc;
    logic [FW-1:0] rem_after;
    logic [AW:0]   wsum;
    logic [AW-1:0] waddr;
    logic [AW-1:0] head_inc;

    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] prev_byte;
    logic [BYTE_W-1:0] operand;
    logic [BYTE_W:0]   sum9;
    logic [BYTE_W-1:0] res_byte;
    logic [BYTE_W-1:0] new_prev_byte;
    logic [PREV_W-1:0] acc_new;
    logic              word_end;
    logic              samp_end;
    logic              more;
    logic              last_init;

    // effective geometry
    always_comb begin
        if (word_reg == 3'd0) begin
            w = 3'd1;
        end else if (word_reg > 3'd4) begin
            w = 3'd4;
        end else begin
            w = word_reg;
        end
        case (w)
            3'd1:    lim = LIM1;
            3'd2:    lim = LIM2;
            3'd3:    lim = LIM3;
            default: lim = LIM4;
        endcase
        c7 = {2'b00, chan_cnt_reg};
        if (c7 == 7'd0) begin
            c7 = 7'd1;
        end
        if (c7 > MAXCH) begin
            c7 = MAXCH;
        end
        if (c7 > lim) begin
            c7 = lim;
        end
        nch     = c7[4:0];
        ssize_w = {5'b00000, w} * {3'b000, nch};
        ssize   = ssize_w[FW-1:0];
        w_m1    = 2'(w - 3'd1);
    end

    assign fill_inc  = fill_reg + FW'(1);
    assign rem_after = fill_reg - FW'(1);

    // write slot is head + fill, wrapped once around the buffer
    always_comb begin
        wsum = (AW + 1)'(head_reg) + (AW + 1)'(fill_reg);
        if (wsum >= DEPTH_X) begin
            wsum = wsum - DEPTH_X;
        end
        waddr = wsum[AW-1:0];
    end

    assign head_inc = (head_reg == HEAD_LAST) ? '0 : head_reg + AW'(1);

    mcdc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_SAMPLE_BYTES)
    ) u_buf (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (waddr),
        .wdata (in_byte),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // byte-serial add (decode) or subtract via inverted operand (encode)
    always_comb begin
        prev_byte     = prev_reg[chan_reg][8 * byte_reg +: 8];
        operand       = dir_reg ? prev_byte : ~prev_byte;
        sum9          = {1'b0, ram_rdata} + {1'b0, operand} + {8'h00, carry_reg};
        res_byte      = sum9[BYTE_W-1:0];
        new_prev_byte = dir_reg ? res_byte : ram_rdata;
        acc_new       = (byte_reg == 2'd0) ? '0 : acc_reg;
        case (byte_reg)
            2'd0:    acc_new[7:0]   = new_prev_byte;
            2'd1:    acc_new[15:8]  = new_prev_byte;
            2'd2:    acc_new[23:16] = new_prev_byte;
            default: acc_new[31:24] = new_prev_byte;
        endcase
    end

    assign word_end = (byte_reg == w_m1);
    assign samp_end = (samp_left_reg == FW'(1));

    always_comb begin
        if (raw_reg) begin
            more = (rem_after != '0);
        end else if (samp_end) begin
            more = (rem_after >= ssize) || (end_reg && (rem_after != '0));
        end else begin
            more = 1'b1;
        end
    end

    assign last_init        = (fill_inc < ssize);
    assign stat.start_work  = !last_init || in_end;
    assign stat.out_free    = !out_valid_reg || m_tready;
    assign stat.more        = more;

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg       <= 1'b0;
            chan_cnt_reg  <= 5'd1;
            word_reg      <= 3'd1;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                prev_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_DIRECTION:     dir_reg      <= cfg_data[0];
                    REG_CHANNEL_COUNT: chan_cnt_reg <= cfg_data;
                    REG_WORD_BYTES:    word_reg     <= cfg_data[2:0];
                    default:           ;
                endcase
            end
            if (cmd.accept) begin
                fill_reg <= fill_inc;
            end
            if (cmd.emit) begin
                head_reg      <= head_inc;
                fill_reg      <= rem_after;
                out_valid_reg <= 1'b1;
                if (!raw_reg && word_end) begin
                    prev_reg[chan_reg] <= acc_new;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sequencing counters and payload, loaded before use
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            end_reg       <= in_end;
            raw_reg       <= last_init;
            samp_left_reg <= ssize;
            chan_reg      <= '0;
            byte_reg      <= 2'd0;
            carry_reg     <= !dir_reg;
        end
        if (cmd.emit) begin
            out_byte_reg <= raw_reg ? ram_rdata : res_byte;
            out_last_reg <= !more;
            out_raw_reg  <= raw_reg;
            if (!raw_reg) begin
                acc_reg       <= acc_new;
                samp_left_reg <= samp_left_reg - FW'(1);
                if (word_end) begin
                    byte_reg  <= 2'd0;
                    chan_reg  <= chan_reg + CW'(1);
                    carry_reg <= !dir_reg;
                end else begin
                    byte_reg  <= byte_reg + 2'd1;
                    carry_reg <= sum9[BYTE_W];
                end
                if (samp_end) begin
                    // start the next sample, or fall into the raw tail
                    samp_left_reg <= ssize;
                    chan_reg      <= '0;
                    raw_reg       <= (rem_after < ssize);
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_raw_reg;

endmodule

/* rtl/multichannel_delta_codec.sv */
// Channel    Direction  Handshake            Payload
// s_         in         s_tvalid/s_tready    tdata data_byte, tlast stream_end
// m_         out        m_tvalid/m_tready    tdata out_byte, tlast run_last,
//                                            tuser raw_tail
// cfg_       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An input byte that completes no sample and ends no stream is only buffered
// and the sequencer stays idle. For each result byte that a byte releases,
// the sequencer passes a buffer RAM read state and an output register load
// state. Reset (aresetn low, synchronous) sets configuration to defaults and
// clears fill, head and previous words at once; there is no clearing pass.
// A stalled m_ side holds the sequencer in its emit state; the last result
// byte waits in the output register while the next input byte is taken.
module multichannel_delta_codec #(
    parameter int MAX_CHANNELS     = 16,
    parameter int MAX_SAMPLE_BYTES = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,    // [7:0] data_byte
    input  logic                             s_tlast,    // stream_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,    // [7:0] out_byte
    output logic                             m_tlast,    // run_last
    output logic                             m_tuser,    // [0] raw_tail
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mcdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import mcdc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    mcdc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcdc_datapath #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

/* rtl/mcdc_checker.sv */
// Port-level checks of the multichannel delta codec, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mcdc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // a stalled result transfer keeps its payload
    `MCDC_ASSERT_RST(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))

    // no result survives reset
    `MCDC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

    // while taking input, only the last byte of a run may be pending
    `MCDC_ASSERT_RST(a_idle_last, aclk, aresetn, (s_tready && m_tvalid) |-> m_tlast)

    // a stalled non-final byte keeps the run in progress
    `MCDC_ASSERT_RST(a_run_busy, aclk, aresetn, (m_tvalid && !m_tready && !m_tlast) |=> !s_tready)

endmodule

bind multichannel_delta_codec mcdc_checker u_mcdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
